### rtl/cra_pkg.sv
// Shared types, widths and codes of the coalescing range allocator.
package cra_pkg;

  localparam int PAGE_W = 36;
  localparam int LEN_W = 24;
  localparam int FREE_SLOTS_DEF = 32;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_TABLE_FULL = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  localparam logic REG_POOL_FIRST = 1'b0;
  localparam logic REG_POOL_PAGES = 1'b1;

  localparam logic OP_TAKE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [PAGE_W-1:0] PAGE_MAX = '1;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [PAGE_W-1:0] start;
  } entry_t;

  typedef struct packed {
    logic            sub;
    logic [PAGE_W:0] a;
    logic [PAGE_W:0] b;
  } alu_req_t;

endpackage

### rtl/cra_alu.sv
// Shared add and subtract unit; the top bit of a difference flags a borrow.
module cra_alu
  import cra_pkg::*;
(
  input  alu_req_t          req,
  output logic [PAGE_W+1:0] res
);

  always_comb begin
    if (req.sub) begin
      res = {1'b0, req.a} - {1'b0, req.b};
    end else begin
      res = {1'b0, req.a} + {1'b0, req.b};
    end
  end

endmodule

### rtl/coalescing_range_allocator_unit.sv
// Top level of the coalescing range allocator: sequencer, free table and shared adder.
//
// Input transfers on the s_ group carry one request: s_tuser is the operation (0 take,
// 1 release), s_tdata holds the start page and the length in pages. Each request gives
// exactly one result on the m_ group: m_tuser is the status, m_tdata the granted page.
// Configuration writes on the cfg_ group set the pool start (index 0) and the pool size
// (index 1); they are latched into the allocator on the first take after reset.
// How long a request occupies the block grows with the number of free table entries in
// use: the table is scanned one entry a cycle through its one read port, and a removal
// or an insertion moves the entries behind it one a cycle. The next request is taken
// only after the result has gone into the output register.
// All page and length arithmetic goes through the one shared adder, one step a
// cycle. s_tready is high only while the block is idle, so one request is in work at a
// time. The result waits in an output register; while the receiver stalls, the block
// still takes the next request and holds its finished result until the register frees.
// Reset empties the free table, clears the cursor and the pool latch and drops any
// pending result. The table needs no clearing pass.
module coalescing_range_allocator_unit
  import cra_pkg::*;
#(
  parameter int FREE_SLOTS = FREE_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // range_page [35:0], range_pages [59:36]
  input  logic        s_tuser,   // operation [0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // granted_page [35:0]
  output logic [1:0]  m_tuser,   // status [1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [35:0] cfg_data
);

  localparam int AW = $clog2(FREE_SLOTS);
  localparam int CW = $clog2(FREE_SLOTS + 1);
  localparam int XW = PAGE_W + 1 - LEN_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_REL_END = 4'd2;
  localparam logic [3:0] S_SCAN = 4'd3;
  localparam logic [3:0] S_SPLIT = 4'd4;
  localparam logic [3:0] S_BUMP = 4'd5;
  localparam logic [3:0] S_BUMP_ADV = 4'd6;
  localparam logic [3:0] S_PSUM = 4'd7;
  localparam logic [3:0] S_PCHK = 4'd8;
  localparam logic [3:0] S_SSUM = 4'd9;
  localparam logic [3:0] S_SCHK = 4'd10;
  localparam logic [3:0] S_CUR = 4'd11;
  localparam logic [3:0] S_INS = 4'd12;
  localparam logic [3:0] S_SHUP = 4'd13;
  localparam logic [3:0] S_SHDN = 4'd14;
  localparam logic [3:0] S_DONE = 4'd15;

  logic [3:0]        state;
  logic [3:0]        ret;
  logic              op;
  logic [PAGE_W-1:0] beg;
  logic [LEN_W-1:0]  size;
  logic [PAGE_W:0]   end_pg;
  logic [PAGE_W:0]   tmp;
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     pos;
  logic [CW-1:0]     sh_k;
  logic [PAGE_W-1:0] cursor;
  logic [PAGE_W-1:0] limit;
  logic              started;
  logic [PAGE_W-1:0] pool_first;
  logic [LEN_W-1:0]  pool_pages;
  logic              have_pred;
  logic [PAGE_W-1:0] pred_start;
  logic [LEN_W-1:0]  pred_len;
  logic              succ_valid;
  logic [PAGE_W-1:0] succ_start;
  logic [LEN_W-1:0]  succ_len;
  logic              pmerge;
  logic              smerge;
  logic [LEN_W-1:0]  diff_len;
  logic [PAGE_W-1:0] grant;
  logic [1:0]        status;

  entry_t            mem [FREE_SLOTS];
  entry_t            rdata;
  entry_t            wdata;
  logic [AW-1:0]     raddr;
  logic [AW-1:0]     waddr;
  logic              we;

  alu_req_t          alu_req;
  logic [PAGE_W+1:0] alu_res;

  logic [CW-1:0]     idx_inc;
  logic [CW-1:0]     pos_dec;
  logic [CW-1:0]     pos_adj;
  logic [CW-1:0]     adj_inc;
  logic [CW-1:0]     cnt_dec;
  logic [CW-1:0]     shk_inc2;
  logic [CW-1:0]     shk_dec2;
  logic [CW:0]       shk_inc;
  logic              shk_more;
  logic              s_fire;
  logic              out_free;
  logic              pred_merge;
  logic              succ_merge;
  logic              bump_fail;
  logic [PAGE_W:0]   size_x;

  cra_alu u_alu (
    .req(alu_req),
    .res(alu_res)
  );

  assign s_tready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign s_fire = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign size_x = {{XW{1'b0}}, size};
  assign idx_inc = idx + CW'(1);
  assign pos_dec = pos - CW'(1);
  assign pos_adj = pmerge ? pos_dec : pos;
  assign adj_inc = pos_adj + CW'(1);
  assign cnt_dec = cnt - CW'(1);
  assign shk_inc2 = sh_k + CW'(2);
  assign shk_dec2 = sh_k - CW'(2);
  assign shk_inc = {1'b0, sh_k} + {{CW{1'b0}}, 1'b1};
  assign shk_more = shk_inc < {1'b0, cnt};

  assign pred_merge = have_pred && (tmp == {1'b0, beg}) && (alu_res[PAGE_W+1:LEN_W] == '0);
  assign succ_merge = succ_valid && ({1'b0, succ_start} == end_pg) &&
                      (alu_res[PAGE_W+1:LEN_W] == '0);
  assign bump_fail = (cursor == '0) || alu_res[PAGE_W+1] || (size_x > alu_res[PAGE_W:0]);

  always_comb begin
    alu_req = '0;
    raddr = '0;
    we = 1'b0;
    waddr = '0;
    wdata = rdata;
    unique case (state)
      S_START: begin
        alu_req = '{sub: 1'b0, a: {1'b0, pool_first}, b: {{XW{1'b0}}, pool_pages}};
      end
      S_REL_END: begin
        alu_req = '{sub: 1'b0, a: {1'b0, beg}, b: size_x};
      end
      S_SCAN: begin
        raddr = idx_inc[AW-1:0];
        if (op == OP_TAKE) begin
          alu_req = '{sub: 1'b1, a: {{XW{1'b0}}, rdata.len}, b: size_x};
        end else begin
          alu_req = '{sub: 1'b1, a: {1'b0, rdata.start}, b: {1'b0, beg}};
        end
      end
      S_SPLIT: begin
        alu_req = '{sub: 1'b0, a: {1'b0, grant}, b: size_x};
        we = 1'b1;
        waddr = idx[AW-1:0];
        wdata = '{len: diff_len, start: alu_res[PAGE_W-1:0]};
      end
      S_BUMP: begin
        alu_req = '{sub: 1'b1, a: {1'b0, limit}, b: {1'b0, cursor}};
      end
      S_BUMP_ADV: begin
        alu_req = '{sub: 1'b0, a: {1'b0, cursor}, b: size_x};
      end
      S_PSUM: begin
        alu_req = '{sub: 1'b0, a: {1'b0, pred_start}, b: {{XW{1'b0}}, pred_len}};
      end
      S_PCHK: begin
        alu_req = '{sub: 1'b1, a: end_pg, b: {1'b0, pred_start}};
        raddr = pos[AW-1:0];
      end
      S_SSUM: begin
        alu_req = '{sub: 1'b0, a: end_pg, b: {{XW{1'b0}}, succ_len}};
      end
      S_SCHK: begin
        alu_req = '{sub: 1'b1, a: tmp, b: {1'b0, beg}};
        raddr = adj_inc[AW-1:0];
      end
      S_INS: begin
        alu_req = '{sub: 1'b1, a: end_pg, b: {1'b0, beg}};
        raddr = cnt_dec[AW-1:0];
      end
      S_SHUP: begin
        we = 1'b1;
        if (sh_k > pos) begin
          waddr = sh_k[AW-1:0];
          raddr = shk_dec2[AW-1:0];
        end else begin
          waddr = pos[AW-1:0];
          wdata = '{len: diff_len, start: beg};
        end
      end
      S_SHDN: begin
        if (shk_more) begin
          we = 1'b1;
          waddr = sh_k[AW-1:0];
          raddr = shk_inc2[AW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret <= S_IDLE;
      cnt <= '0;
      cursor <= '0;
      limit <= '0;
      started <= 1'b0;
      pool_first <= '0;
      pool_pages <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_POOL_FIRST: pool_first <= cfg_data;
          REG_POOL_PAGES: pool_pages <= cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_fire) begin
            op <= s_tuser;
            beg <= s_tdata[PAGE_W-1:0];
            size <= s_tdata[PAGE_W+LEN_W-1:PAGE_W];
            grant <= '0;
            if (s_tdata[PAGE_W+LEN_W-1:PAGE_W] == '0) begin
              status <= ST_INVALID;
              state <= S_DONE;
            end else if (s_tuser == OP_TAKE) begin
              status <= ST_OK;
              state <= S_START;
            end else begin
              status <= ST_OK;
              state <= S_REL_END;
            end
          end
        end
        S_START: begin
          if (!started) begin
            started <= 1'b1;
            if (pool_first != '0) begin
              cursor <= pool_first;
              limit <= alu_res[PAGE_W] ? PAGE_MAX : alu_res[PAGE_W-1:0];
            end
          end
          idx <= '0;
          state <= S_SCAN;
        end
        S_REL_END: begin
          end_pg <= alu_res[PAGE_W:0];
          have_pred <= 1'b0;
          idx <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (op == OP_TAKE) begin
            if (idx == cnt) begin
              state <= S_BUMP;
            end else if (!alu_res[PAGE_W+1]) begin
              grant <= rdata.start;
              if (alu_res == '0) begin
                sh_k <= idx;
                ret <= S_DONE;
                state <= S_SHDN;
              end else begin
                diff_len <= alu_res[LEN_W-1:0];
                state <= S_SPLIT;
              end
            end else begin
              idx <= idx_inc;
            end
          end else begin
            if (idx == cnt || !alu_res[PAGE_W+1]) begin
              pos <= idx;
              succ_valid <= (idx != cnt);
              succ_start <= rdata.start;
              succ_len <= rdata.len;
              state <= S_PSUM;
            end else begin
              have_pred <= 1'b1;
              pred_start <= rdata.start;
              pred_len <= rdata.len;
              idx <= idx_inc;
            end
          end
        end
        S_SPLIT: begin
          state <= S_DONE;
        end
        S_BUMP: begin
          if (bump_fail) begin
            status <= ST_NO_SPACE;
            state <= S_DONE;
          end else begin
            grant <= cursor;
            state <= S_BUMP_ADV;
          end
        end
        S_BUMP_ADV: begin
          cursor <= alu_res[PAGE_W-1:0];
          state <= S_DONE;
        end
        S_PSUM: begin
          tmp <= alu_res[PAGE_W:0];
          pmerge <= 1'b0;
          smerge <= 1'b0;
          state <= S_PCHK;
        end
        S_PCHK: begin
          if (pred_merge) begin
            beg <= pred_start;
            pmerge <= 1'b1;
            sh_k <= pos_dec;
            ret <= S_SSUM;
            state <= S_SHDN;
          end else begin
            state <= S_SSUM;
          end
        end
        S_SSUM: begin
          tmp <= alu_res[PAGE_W:0];
          state <= S_SCHK;
        end
        S_SCHK: begin
          if (succ_merge) begin
            end_pg <= tmp;
            smerge <= 1'b1;
            sh_k <= pos_adj;
            ret <= S_CUR;
            state <= S_SHDN;
          end else begin
            state <= S_CUR;
          end
        end
        S_CUR: begin
          if (end_pg == {1'b0, cursor}) begin
            cursor <= beg;
            state <= S_DONE;
          end else if (!smerge && succ_valid && succ_start == beg) begin
            state <= S_DONE;
          end else if (cnt == CW'(FREE_SLOTS)) begin
            status <= ST_TABLE_FULL;
            state <= S_DONE;
          end else begin
            state <= S_INS;
          end
        end
        S_INS: begin
          diff_len <= alu_res[LEN_W-1:0];
          pos <= pos_adj;
          sh_k <= cnt;
          state <= S_SHUP;
        end
        S_SHUP: begin
          if (sh_k > pos) begin
            sh_k <= sh_k - CW'(1);
          end else begin
            cnt <= cnt + CW'(1);
            state <= S_DONE;
          end
        end
        S_SHDN: begin
          if (shk_more) begin
            sh_k <= shk_inc[CW-1:0];
          end else begin
            cnt <= cnt_dec;
            state <= ret;
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser <= status;
            m_tdata <= {4'b0, (status == ST_OK) ? grant : {PAGE_W{1'b0}}};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/cra_checker.sv
// Port-level checks of the coalescing range allocator and their binding to the top level.
module cra_checker
  import cra_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [1:0]  m_tuser
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("Block is not idle and empty after reset.");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("Input accepted again while a request is in work.");

  a_grant_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_OK |-> m_tdata == '0)
    else $error("Failed request carries a granted page.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("Stalled result changed.");

endmodule

bind coalescing_range_allocator_unit cra_checker u_cra_checker (.*);
